>>> rtl/ddm_pkg.sv
// Shared types, constants and helper functions of the decimal digit multiplier.
package ddm_pkg;

	localparam int DIGIT_W     = 4;
	localparam int ACC_W       = 12;
	localparam int RECIP       = 3277;
	localparam int RECIP_SHIFT = 15;

	typedef enum logic [2:0] {
		S_LOAD,
		S_INIT,
		S_COL,
		S_MAC,
		S_DRAIN,
		S_DIGIT,
		S_FINAL,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic init;
		logic col;
		logic mac;
		logic digit;
		logic fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic mac_last;
		logic col_last;
		logic emit_last;
	} status_t;

	function automatic logic [DIGIT_W-1:0] clamp_digit(input logic [DIGIT_W-1:0] d);
		return (d > DIGIT_W'(9)) ? DIGIT_W'(9) : d;
	endfunction

	// Exact quotient by ten for every 12-bit value, by reciprocal multiplication.
	function automatic logic [ACC_W-1:0] div10(input logic [ACC_W-1:0] v);
		logic [2*ACC_W-1:0] p;
		p = {{ACC_W{1'b0}}, v} * (2*ACC_W)'(RECIP);
		return ACC_W'(p >> RECIP_SHIFT);
	endfunction

endpackage

>>> rtl/ddm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ddm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/ddm_datapath.sv
// Datapath: operand stores, column multiply-accumulate, carry split and product readout.
module ddm_datapath import ddm_pkg::*; #(
	parameter int MAX_DIGITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            st,
	input  logic [DIGIT_W-1:0] digit_a,
	input  logic [DIGIT_W-1:0] digit_b,
	output logic [DIGIT_W-1:0] product_digit,
	output logic               result_strobe,
	output logic               last_of_product,
	output logic               truncated
);

	localparam int CW     = $clog2(MAX_DIGITS + 1);
	localparam int AW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int PDEPTH = 2 * MAX_DIGITS;
	localparam int PAW    = $clog2(PDEPTH);

	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [PAW-1:0]     k_q;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      i_hi_q;
	logic [PAW-1:0]     pos_q;
	logic [ACC_W-1:0]   acc_q;
	logic               term_s1;
	logic               emit_s1;
	logic               last_s1;
	logic               trunc_s1;

	logic [PAW-1:0]     n_ext;
	logic [PAW-1:0]     i_ext;
	logic [PAW-1:0]     i_lo_w;
	logic [PAW-1:0]     i_hi_w;
	logic [PAW-1:0]     addr_a_w;
	logic [PAW-1:0]     addr_b_w;
	logic [PAW:0]       k_x;
	logic [PAW:0]       n2_x;
	logic [DIGIT_W-1:0] rd_a;
	logic [DIGIT_W-1:0] rd_b;
	logic [2*DIGIT_W-1:0] mul_w;
	logic [ACC_W-1:0]   quot_w;
	logic [ACC_W-1:0]   rem_full_w;
	logic [DIGIT_W-1:0] rem_w;
	logic               dig_we;

	assign n_ext  = PAW'(count_q);
	assign i_ext  = PAW'(i_q);
	assign k_x    = {1'b0, k_q};
	assign n2_x   = (PAW + 1)'(count_q) << 1;

	// Term range of column k: weights i with both i and k - i below n.
	assign i_lo_w   = (k_q >= n_ext) ? (k_q - n_ext + 1'b1) : '0;
	assign i_hi_w   = (k_q < n_ext) ? k_q : (n_ext - 1'b1);
	// Digits are stored most significant first, so weight w lives at n - 1 - w.
	assign addr_a_w = n_ext - 1'b1 - i_ext;
	assign addr_b_w = n_ext - 1'b1 - (k_q - i_ext);

	assign st.full      = (count_q == CW'(MAX_DIGITS));
	assign st.mac_last  = (i_q == i_hi_q);
	assign st.col_last  = ((k_x + 2'd2) == n2_x);
	assign st.emit_last = (pos_q == '0);

	assign dig_we = cmd.load & ~st.full;

	ddm_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_ram_a (
		.clk   (clk),
		.we    (dig_we),
		.waddr (count_q[AW-1:0]),
		.wdata (clamp_digit(digit_a)),
		.raddr (addr_a_w[AW-1:0]),
		.rdata (rd_a)
	);

	ddm_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_ram_b (
		.clk   (clk),
		.we    (dig_we),
		.waddr (count_q[AW-1:0]),
		.wdata (clamp_digit(digit_b)),
		.raddr (addr_b_w[AW-1:0]),
		.rdata (rd_b)
	);

	assign mul_w      = {{DIGIT_W{1'b0}}, rd_a} * {{DIGIT_W{1'b0}}, rd_b};
	assign quot_w     = div10(acc_q);
	assign rem_full_w = acc_q - ((quot_w << 3) + (quot_w << 1));
	assign rem_w      = rem_full_w[DIGIT_W-1:0];

	ddm_ram #(.WIDTH(DIGIT_W), .DEPTH(PDEPTH)) u_ram_p (
		.clk   (clk),
		.we    (cmd.digit | cmd.fin),
		.waddr (k_q),
		.wdata (rem_w),
		.raddr (pos_q),
		.rdata (product_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			acc_q    <= '0;
			term_s1  <= 1'b0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
			trunc_s1 <= 1'b0;
		end else begin
			term_s1  <= cmd.mac;
			emit_s1  <= cmd.emit;
			last_s1  <= cmd.emit & st.emit_last;
			trunc_s1 <= ovf_q;

			if (cmd.emit && st.emit_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.load) begin
				if (!st.full) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end

			priority if (cmd.init) begin
				acc_q <= '0;
			end else if (cmd.digit) begin
				acc_q <= quot_w;
			end else if (term_s1) begin
				acc_q <= acc_q + ACC_W'(mul_w);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			k_q <= '0;
		end else if (cmd.digit) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.col) begin
			i_q    <= i_lo_w[AW-1:0];
			i_hi_q <= i_hi_w[AW-1:0];
		end else if (cmd.mac) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.fin) begin
			pos_q <= k_q;
		end else if (cmd.emit) begin
			pos_q <= pos_q - 1'b1;
		end
	end

	assign result_strobe   = emit_s1;
	assign last_of_product = last_s1;
	assign truncated       = trunc_s1;

endmodule

>>> rtl/ddm_ctrl.sv
// Controller state machine that sequences loading, column accumulation and readout.
module ddm_ctrl import ddm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    last_digit,
	input  status_t st,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD:  if (start && last_digit) state_d = S_INIT;
			S_INIT:  state_d = S_COL;
			S_COL:   state_d = S_MAC;
			S_MAC:   if (st.mac_last) state_d = S_DRAIN;
			S_DRAIN: state_d = S_DIGIT;
			S_DIGIT: state_d = st.col_last ? S_FINAL : S_COL;
			S_FINAL: state_d = S_EMIT;
			S_EMIT:  if (st.emit_last) state_d = S_LOAD;
			default: state_d = S_LOAD;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_LOAD: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_INIT:  cmd.init  = 1'b1;
			S_COL:   cmd.col   = 1'b1;
			S_MAC:   cmd.mac   = 1'b1;
			S_DRAIN: cmd       = '0;
			S_DIGIT: cmd.digit = 1'b1;
			S_FINAL: cmd.fin   = 1'b1;
			S_EMIT:  cmd.emit  = 1'b1;
			default: cmd       = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/decimal_digit_multiplier_core.sv
// Top level of the decimal digit multiplier: controller, datapath and checks.
//
// Digit pairs of two equal-length decimal operands are transferred most
// significant first, one per cycle, whenever start is high and busy is low.
// A plain pair leaves busy low. The pair marked by last_digit starts the
// product: with n pairs held, busy stays high while the single shared
// multiply-accumulate walks every digit product of every column once, one
// term per cycle, with a carry split after each column, and then through
// the readout from the product memory. The 2n product digits come out most
// significant first on consecutive cycles, each valid for exactly one cycle
// under result_strobe; the receiver cannot stall and must take every
// transfer. last_of_product marks the least significant digit. Digits above
// nine are taken as nine. Pairs beyond MAX_DIGITS are dropped, the product
// is formed from the pairs that were kept, and truncated is set on every
// digit of that product. Operand stores and the product memory need no
// clearing after reset, since only entries written for the current product
// are ever read.
module decimal_digit_multiplier_core import ddm_pkg::*; #(
	parameter int MAX_DIGITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [DIGIT_W-1:0] digit_a,
	input  logic [DIGIT_W-1:0] digit_b,
	input  logic               last_digit,
	output logic               result_strobe,
	output logic [DIGIT_W-1:0] product_digit,
	output logic               last_of_product,
	output logic               truncated
);

	cmd_t    cmd;
	status_t st;

	// The controller only sequences; every counter and store sits in the datapath.
	ddm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_digit (last_digit),
		.st         (st),
		.cmd        (cmd),
		.busy       (busy)
	);

	ddm_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.digit_a         (digit_a),
		.digit_b         (digit_b),
		.product_digit   (product_digit),
		.result_strobe   (result_strobe),
		.last_of_product (last_of_product),
		.truncated       (truncated)
	);

	// The final digit only ever follows a cycle in which the block was busy.
	a_last_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_of_product) |-> $past(busy))
		else $error("final product digit without a preceding busy cycle");

	// The last-digit mark never appears outside a result transfer.
	a_last_needs_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_of_product |-> result_strobe)
		else $error("last_of_product without result_strobe");

	// Product digits are transferred back to back until the final one.
	a_digits_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_of_product) |=> result_strobe)
		else $error("gap in product digit stream");

	// A loading transfer never starts the product.
	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_digit) |=> !busy)
		else $error("busy raised by a plain loading transfer");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the decimal digit multiplier core.
module tb_top;
	import ddm_pkg::*;

	localparam int MAX_DIGITS = 32;
	// Idling stops this many items before the end of the random part.
	localparam int CALM_TAIL  = 60;
	localparam int ITEM_GOAL  = 380;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [DIGIT_W-1:0] digit_a;
	logic [DIGIT_W-1:0] digit_b;
	logic               last_digit;
	logic               result_strobe;
	logic [DIGIT_W-1:0] product_digit;
	logic               last_of_product;
	logic               truncated;

	int mismatches = 0;
	int items_sent = 0;

	// One expected product digit as it should appear on the result ports.
	typedef struct {
		logic [DIGIT_W-1:0] digit;
		logic               is_last;
		logic               was_truncated;
	} product_digit_t;

	// Keeps its own copy of the operand digits and, on every pair that closes
	// an operand, works out the full product by exact column sums with decimal
	// carries. The digits due are held most significant first, in the order
	// the core sends them.
	class product_scoreboard;
		int             a_held[MAX_DIGITS];
		int             b_held[MAX_DIGITS];
		int             held_count = 0;
		bit             dropped_pairs = 0;
		product_digit_t digits_due[$];

		function int pending();
			return digits_due.size();
		endfunction

		// Called for every accepted transfer on the input side.
		function void note_input(logic [DIGIT_W-1:0] a, logic [DIGIT_W-1:0] b, logic last);
			if (held_count < MAX_DIGITS) begin
				// Digits above nine are taken as nine.
				a_held[held_count] = (a > 9) ? 9 : int'(a);
				b_held[held_count] = (b > 9) ? 9 : int'(b);
				held_count++;
			end else begin
				dropped_pairs = 1'b1;
			end
			if (last) begin
				expect_product();
				held_count = 0;
				dropped_pairs = 1'b0;
			end
		endfunction

		// Column k of the product collects a_w(i) * b_w(k-i), weights counted
		// from the least significant digit; the carry goes to column k+1.
		function void expect_product();
			int             n;
			int             carry;
			int             col_sum;
			int             digits[2*MAX_DIGITS];
			product_digit_t pd;
			n = held_count;
			carry = 0;
			for (int k = 0; k < 2*n - 1; k++) begin
				col_sum = carry;
				for (int i = 0; i < n; i++) begin
					if (k - i >= 0 && k - i < n)
						col_sum += a_held[n-1-i] * b_held[n-1-(k-i)];
				end
				col_sum &= 'hFFF;
				digits[k] = col_sum % 10;
				carry = col_sum / 10;
			end
			digits[2*n-1] = carry % 10;
			for (int w = 2*n - 1; w >= 0; w--) begin
				pd.digit = DIGIT_W'(digits[w]);
				pd.is_last = (w == 0);
				pd.was_truncated = dropped_pairs;
				digits_due.push_back(pd);
			end
		endfunction

		// Compares one result transfer with the oldest digit due.
		function bit check_result(logic [DIGIT_W-1:0] d, logic l, logic t, output string why);
			product_digit_t pd;
			why = "";
			if (digits_due.size() == 0) begin
				why = $sformatf("unexpected product digit %0d (last %b, truncated %b)", d, l, t);
				return 1'b0;
			end
			pd = digits_due.pop_front();
			if (d !== pd.digit)
				why = {why, $sformatf(" digit %0d, expected %0d;", d, pd.digit)};
			if (l !== pd.is_last)
				why = {why, $sformatf(" last_of_product %b, expected %b;", l, pd.is_last)};
			if (t !== pd.was_truncated)
				why = {why, $sformatf(" truncated %b, expected %b;", t, pd.was_truncated)};
			return why == "";
		endfunction
	endclass

	product_scoreboard sb = new;

	decimal_digit_multiplier_core #(.MAX_DIGITS(MAX_DIGITS)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.digit_a         (digit_a),
		.digit_b         (digit_b),
		.last_digit      (last_digit),
		.result_strobe   (result_strobe),
		.product_digit   (product_digit),
		.last_of_product (last_of_product),
		.truncated       (truncated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string why);
		$display("MISMATCH at %0t:%s", $time, why);
		mismatches++;
	endtask

	// The core cannot be held off, so every strobe is a transfer. Values read
	// right after the rising edge are still the ones the edge sampled, since
	// the core updates its registers in the nonblocking region.
	always @(posedge clk) begin
		string why;
		if (arst_n && result_strobe === 1'b1) begin
			if (!sb.check_result(product_digit, last_of_product, truncated, why))
				report_mismatch(why);
		end
	end

	// Drives one digit pair from the falling edge and holds it until a rising
	// edge finds busy low. start stays high so back-to-back pairs need no
	// extra cycle; an idle burst lowers it on a later falling edge.
	task automatic send_pair(input logic [DIGIT_W-1:0] a, input logic [DIGIT_W-1:0] b,
			input logic last);
		@(negedge clk);
		start = 1'b1;
		digit_a = a;
		digit_b = b;
		last_digit = last;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_input(a, b, last);
		items_sent++;
	endtask

	// Sends two operands of n digits, packed as nibbles, most significant
	// nibble first; the final pair carries last_digit.
	task automatic send_operands(input int n, input logic [31:0] a_word, input logic [31:0] b_word);
		for (int i = 0; i < n; i++)
			send_pair(a_word[4*(n-1-i) +: 4], b_word[4*(n-1-i) +: 4], i == n - 1);
	endtask

	// An idle burst with start low, of a randomly drawn length.
	task automatic idle_burst();
		int cycles;
		cycles = $urandom_range(1, 17);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Mostly legal digits, with the codes above nine mixed in now and then.
	function automatic logic [DIGIT_W-1:0] random_digit();
		if ($urandom_range(0, 99) < 85)
			return DIGIT_W'($urandom_range(0, 9));
		return DIGIT_W'($urandom_range(10, 15));
	endfunction

	initial begin
		int  seq_len;
		int  pick;
		int  seq_count;
		bit  idling;
		arst_n = 1'b0;
		start = 1'b0;
		digit_a = '0;
		digit_b = '0;
		last_digit = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: single-digit extremes, codes above nine clamped to
		// nine, leading zeros in the product, full carry chains, and a
		// product with no carries.
		send_operands(1, 'h0, 'h0);
		send_operands(1, 'h9, 'h9);
		send_operands(1, 'hF, 'hA);
		send_operands(1, 'hC, 'h0);
		send_operands(2, 'h01, 'h01);
		send_operands(3, 'h999, 'h9E9);
		send_operands(4, 'h1234, 'h5678);
		send_operands(4, 'hFFFF, 'h0001);

		// Random part: well-formed operand pairs with random content. The
		// first two run the store exactly full and one pair past capacity;
		// after that most operands are short, a few fill the store, and some
		// overrun it so the dropped pairs get flagged.
		seq_count = 0;
		while (items_sent < ITEM_GOAL) begin
			pick = $urandom_range(0, 99);
			if (seq_count == 0)
				seq_len = MAX_DIGITS;
			else if (seq_count == 1)
				seq_len = MAX_DIGITS + 1;
			else if (pick < 60)
				seq_len = $urandom_range(1, 4);
			else if (pick < 80)
				seq_len = $urandom_range(5, 12);
			else if (pick < 88)
				seq_len = $urandom_range(13, MAX_DIGITS - 1);
			else if (pick < 93)
				seq_len = MAX_DIGITS;
			else
				seq_len = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 4);
			seq_count++;
			// Some operands go through with no idling at all.
			idling = $urandom_range(0, 2) != 0;
			for (int i = 0; i < seq_len; i++) begin
				if (idling && items_sent < ITEM_GOAL - CALM_TAIL && $urandom_range(0, 3) == 0)
					idle_burst();
				send_pair(random_digit(), random_digit(), i == seq_len - 1);
			end
		end
		@(negedge clk);
		start = 1'b0;

		// Let the last product drain, then watch a while for stray strobes.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// The slowest correct run stays far below this bound.
	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
